>>> src/aesg_pkg.sv
// shared types, tables and helpers for the aes-128-gcm encryptor
package aesg_pkg;

  typedef enum logic [1:0] {
    CMD_AAD  = 2'd0,
    CMD_DATA = 2'd1,
    CMD_FIN  = 2'd2,
    CMD_BAD  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_CT  = 2'd0,
    KIND_TAG = 2'd1,
    KIND_REJ = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_KEY_HI   = 2'd0,
    REG_KEY_LO   = 2'd1,
    REG_NONCE_HI = 2'd2,
    REG_NONCE_LO = 2'd3
  } reg_idx_t;

  localparam logic [7:0] GF_POLY   = 8'h1B;
  localparam logic [7:0] GH_POLY   = 8'hE1;
  localparam logic [7:0] RCON_INIT = 8'h01;
  localparam int unsigned NUM_RK   = 11;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xt(input logic [7:0] x);
    xt = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
  endfunction

  // next round key from the previous one
  function automatic logic [127:0] next_rk(input logic [127:0] prev, input logic [7:0] rc);
    logic [31:0] t, w0, w1, w2, w3;
    t  = {SBOX[prev[23:16]] ^ rc, SBOX[prev[15:8]], SBOX[prev[7:0]], SBOX[prev[31:24]]};
    w0 = prev[127:96] ^ t;
    w1 = prev[95:64] ^ w0;
    w2 = prev[63:32] ^ w1;
    w3 = prev[31:0] ^ w2;
    next_rk = {w0, w1, w2, w3};
  endfunction

  // leading n bytes kept
  function automatic logic [127:0] byte_mask(input logic [4:0] n);
    byte_mask = ~({128{1'b1}} >> {n, 3'b000});
  endfunction

endpackage

>>> src/aesg_round.sv
// one aes encryption round: sub bytes, shift rows, mix columns (not in the last round), add round key
module aesg_round
  import aesg_pkg::*;
(
  input  logic [127:0] state_i,
  input  logic [127:0] rk_i,
  input  logic         last_i,
  output logic [127:0] state_o
);

  always_comb begin
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a, b, d, e;
    a = '0;
    b = '0;
    d = '0;
    e = '0;
    for (int i = 0; i < 16; i++) begin
      s[i] = state_i[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        t[c*4+w] = SBOX[s[((c+w)%4)*4+w]];
      end
    end
    if (!last_i) begin
      for (int c = 0; c < 4; c++) begin
        a = t[4*c]; b = t[4*c+1]; d = t[4*c+2]; e = t[4*c+3];
        t[4*c]   = xt(a) ^ xt(b) ^ b ^ d ^ e;
        t[4*c+1] = a ^ xt(b) ^ xt(d) ^ d ^ e;
        t[4*c+2] = a ^ b ^ xt(d) ^ xt(e) ^ e;
        t[4*c+3] = xt(a) ^ a ^ b ^ d ^ xt(e);
      end
    end
    for (int i = 0; i < 16; i++) begin
      state_o[127-8*i -: 8] = t[i] ^ rk_i[127-8*i -: 8];
    end
  end

endmodule

>>> src/aesg_ghash.sv
// bit-serial gf(2^128) multiplier, four bits of the operand per cycle
module aesg_ghash
  import aesg_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] x_in,
  input  logic [127:0] h_in,
  output logic         done,
  output logic [127:0] z_out
);

  localparam int unsigned BITS_PER_CYC = 4;

  logic [127:0] x_r, v_r, z_r;
  logic [127:0] x_nxt, v_nxt, z_nxt;
  logic [4:0]   cnt_r;
  logic         busy_r, done_r;

  always_comb begin
    x_nxt = x_r;
    v_nxt = v_r;
    z_nxt = z_r;
    for (int i = 0; i < BITS_PER_CYC; i++) begin
      if (x_nxt[127]) begin
        z_nxt = z_nxt ^ v_nxt;
      end
      x_nxt = {x_nxt[126:0], 1'b0};
      if (v_nxt[0]) begin
        v_nxt = {1'b0, v_nxt[127:1]} ^ {GH_POLY, 120'd0};
      end else begin
        v_nxt = {1'b0, v_nxt[127:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == 5'd31);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        x_r    <= x_in;
        v_r    <= h_in;
        z_r    <= '0;
      end else if (busy_r) begin
        x_r   <= x_nxt;
        v_r   <= v_nxt;
        z_r   <= z_nxt;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done  = done_r;
  assign z_out = z_r;

endmodule

>>> src/aes128_gcm_encryptor_top.sv
// aes-128-gcm encryptor: round key memory, control sequencer, output register
// a data block passes the aes rounds, ghash and emit; an aad block only ghash; finish as a data block
// one transaction at a time, with a shared round unit and the 4-bit ghash loop
// after reset or a key write, the key schedule runs and then the H pass, all
//   before in_tready rises; reset is synchronous, active low
module aes128_gcm_encryptor_top
  import aesg_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 36
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // block_upper, block_lower, byte_count, zero pad
  input  logic [1:0]   in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // result_upper, result_lower, valid_bytes, zero pad
  output logic [1:0]   out_tuser,  // result_kind
  input  logic         cfg_wen,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_wdata
);

  typedef enum logic [2:0] {
    ST_KINIT, ST_KEXP, ST_AES, ST_GH, ST_EMIT, ST_IDLE
  } state_t;

  typedef enum logic [2:0] {
    OP_HKEY, OP_AAD, OP_DATA, OP_FIN, OP_REJ
  } op_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic [63:0]  key_hi_r, key_lo_r, nonce_hi_r;
  logic [63:0]  key_hi_nxt, key_lo_nxt, nonce_hi_nxt;
  logic [31:0]  nonce_lo_r, nonce_lo_nxt;
  logic [127:0] kexp_r, h_r, acc_r, s_r, blk_r;
  logic [127:0] kexp_nxt, h_nxt, acc_nxt, s_nxt, blk_nxt;
  logic [7:0]   rcon_r, rcon_nxt;
  logic [3:0]   widx_r, rnd_r;
  logic [3:0]   widx_nxt, rnd_nxt;
  logic [4:0]   n_r, n_nxt;
  logic [31:0]  ctr_r, ctr_nxt;
  logic [LENGTH_BITS-1:0] aad_tot_r, pay_tot_r;
  logic [LENGTH_BITS-1:0] aad_tot_nxt, pay_tot_nxt;
  logic [1:0]   phase_r, phase_nxt;
  logic         gh_start_r, gh_start_nxt;

  logic         out_valid_r, out_valid_nxt;
  logic [1:0]   out_kind_r, out_kind_nxt;
  logic [127:0] out_blk_r, out_blk_nxt;
  logic [4:0]   out_vb_r, out_vb_nxt;

  // round key memory
  logic [127:0] rk_mem [NUM_RK];
  logic [127:0] rk_q;
  logic         rk_we;
  logic [3:0]   rk_waddr, rk_raddr;
  logic [127:0] rk_wdata, rk_next;

  logic [127:0] round_out, gh_z;
  logic         gh_done;

  logic [127:0] in_blk;
  logic [4:0]   in_n;
  logic [1:0]   in_cmd;
  logic         in_acc;
  logic [LENGTH_BITS:0] aad_sum, pay_sum;
  logic         n_bad;

  assign in_blk  = {in_tdata[63:0], in_tdata[127:64]} & byte_mask(in_tdata[132:128]);
  assign in_n    = in_tdata[132:128];
  assign in_cmd  = in_tuser;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc  = in_tvalid && in_tready;
  assign aad_sum = {1'b0, aad_tot_r} + (LENGTH_BITS+1)'(in_n);
  assign pay_sum = {1'b0, pay_tot_r} + (LENGTH_BITS+1)'(in_n);
  assign n_bad   = (in_n == 5'd0) || (in_n > 5'd16);

  assign rk_next  = next_rk(kexp_r, rcon_r);
  assign rk_we    = (state_r == ST_KINIT) || (state_r == ST_KEXP);
  assign rk_waddr = (state_r == ST_KINIT) ? 4'd0 : widx_r;
  assign rk_wdata = (state_r == ST_KINIT) ? {key_hi_r, key_lo_r} : rk_next;
  assign rk_raddr = (rnd_r > 4'd10) ? 4'd10 : rnd_r;

  always_ff @(posedge clk) begin
    if (rk_we) begin
      rk_mem[rk_waddr] <= rk_wdata;
    end
    rk_q <= rk_mem[rk_raddr];
  end

  aesg_round u_round (
    .state_i (s_r),
    .rk_i    (rk_q),
    .last_i  (rnd_r == 4'd11),
    .state_o (round_out)
  );

  aesg_ghash u_ghash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gh_start_r),
    .x_in  (acc_r ^ blk_r),
    .h_in  (h_r),
    .done  (gh_done),
    .z_out (gh_z)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_hi_nxt    = key_hi_r;
    key_lo_nxt    = key_lo_r;
    nonce_hi_nxt  = nonce_hi_r;
    nonce_lo_nxt  = nonce_lo_r;
    kexp_nxt      = kexp_r;
    h_nxt         = h_r;
    acc_nxt       = acc_r;
    s_nxt         = s_r;
    blk_nxt       = blk_r;
    rcon_nxt      = rcon_r;
    widx_nxt      = widx_r;
    rnd_nxt       = rnd_r;
    n_nxt         = n_r;
    ctr_nxt       = ctr_r;
    aad_tot_nxt   = aad_tot_r;
    pay_tot_nxt   = pay_tot_r;
    phase_nxt     = phase_r;
    gh_start_nxt  = 1'b0;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_blk_nxt   = out_blk_r;
    out_vb_nxt    = out_vb_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_KINIT: begin
        kexp_nxt  = {key_hi_r, key_lo_r};
        rcon_nxt  = RCON_INIT;
        widx_nxt  = 4'd1;
        state_nxt = ST_KEXP;
      end
      ST_KEXP: begin
        kexp_nxt = rk_next;
        rcon_nxt = xt(rcon_r);
        widx_nxt = widx_r + 4'd1;
        if (widx_r == 4'd10) begin
          s_nxt     = '0;
          rnd_nxt   = '0;
          op_nxt    = OP_HKEY;
          state_nxt = ST_AES;
        end
      end
      ST_AES: begin
        rnd_nxt = rnd_r + 4'd1;
        if (rnd_r == 4'd1) begin
          s_nxt = s_r ^ rk_q;
        end else if (rnd_r >= 4'd2) begin
          s_nxt = round_out;
        end
        if (rnd_r == 4'd11) begin
          rnd_nxt = '0;
          case (op_r)
            OP_HKEY: begin
              h_nxt     = round_out;
              state_nxt = ST_IDLE;
            end
            OP_DATA: begin
              blk_nxt      = (blk_r ^ round_out) & byte_mask(n_r);
              gh_start_nxt = 1'b1;
              state_nxt    = ST_GH;
            end
            default: begin
              gh_start_nxt = 1'b1;
              state_nxt    = ST_GH;
            end
          endcase
        end
      end
      ST_GH: begin
        if (gh_done) begin
          case (op_r)
            OP_AAD: begin
              acc_nxt     = gh_z;
              aad_tot_nxt = aad_tot_r + LENGTH_BITS'(n_r);
              if (n_r < 5'd16) begin
                phase_nxt = 2'd1;
              end
              state_nxt = ST_IDLE;
            end
            OP_DATA: begin
              acc_nxt     = gh_z;
              pay_tot_nxt = pay_tot_r + LENGTH_BITS'(n_r);
              phase_nxt   = (n_r < 5'd16) ? 2'd3 : 2'd2;
              state_nxt   = ST_EMIT;
            end
            default: begin
              blk_nxt     = s_r ^ gh_z;
              acc_nxt     = '0;
              ctr_nxt     = 32'd1;
              aad_tot_nxt = '0;
              pay_tot_nxt = '0;
              phase_nxt   = 2'd0;
              state_nxt   = ST_EMIT;
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          case (op_r)
            OP_DATA: begin
              out_kind_nxt = KIND_CT;
              out_blk_nxt  = blk_r;
              out_vb_nxt   = n_r;
            end
            OP_FIN: begin
              out_kind_nxt = KIND_TAG;
              out_blk_nxt  = blk_r;
              out_vb_nxt   = 5'd16;
            end
            default: begin
              out_kind_nxt = KIND_REJ;
              out_blk_nxt  = '0;
              out_vb_nxt   = '0;
            end
          endcase
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          n_nxt   = in_n;
          blk_nxt = in_blk;
          rnd_nxt = '0;
          if (in_cmd == CMD_FIN) begin
            op_nxt    = OP_FIN;
            s_nxt     = {nonce_hi_r, nonce_lo_r, 32'd1};
            blk_nxt   = {64'(aad_tot_r) << 3, 64'(pay_tot_r) << 3};
            state_nxt = ST_AES;
          end else if (in_cmd == CMD_BAD || n_bad) begin
            op_nxt    = OP_REJ;
            state_nxt = ST_EMIT;
          end else if (in_cmd == CMD_AAD) begin
            if (phase_r != 2'd0 || aad_sum[LENGTH_BITS]) begin
              op_nxt    = OP_REJ;
              state_nxt = ST_EMIT;
            end else begin
              op_nxt       = OP_AAD;
              gh_start_nxt = 1'b1;
              state_nxt    = ST_GH;
            end
          end else begin
            if (phase_r == 2'd3 || pay_sum[LENGTH_BITS]) begin
              op_nxt    = OP_REJ;
              state_nxt = ST_EMIT;
            end else begin
              op_nxt    = OP_DATA;
              ctr_nxt   = ctr_r + 32'd1;
              s_nxt     = {nonce_hi_r, nonce_lo_r, ctr_r + 32'd1};
              state_nxt = ST_AES;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_wen) begin
      case (cfg_index)
        REG_KEY_HI: begin
          key_hi_nxt = cfg_wdata;
          state_nxt  = ST_KINIT;
        end
        REG_KEY_LO: begin
          key_lo_nxt = cfg_wdata;
          state_nxt  = ST_KINIT;
        end
        REG_NONCE_HI: nonce_hi_nxt = cfg_wdata;
        REG_NONCE_LO: nonce_lo_nxt = cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_KINIT;
      op_r        <= OP_HKEY;
      key_hi_r    <= '0;
      key_lo_r    <= '0;
      nonce_hi_r  <= '0;
      nonce_lo_r  <= '0;
      acc_r       <= '0;
      ctr_r       <= 32'd1;
      aad_tot_r   <= '0;
      pay_tot_r   <= '0;
      phase_r     <= 2'd0;
      gh_start_r  <= 1'b0;
      rnd_r       <= '0;
      widx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      key_hi_r    <= key_hi_nxt;
      key_lo_r    <= key_lo_nxt;
      nonce_hi_r  <= nonce_hi_nxt;
      nonce_lo_r  <= nonce_lo_nxt;
      acc_r       <= acc_nxt;
      ctr_r       <= ctr_nxt;
      aad_tot_r   <= aad_tot_nxt;
      pay_tot_r   <= pay_tot_nxt;
      phase_r     <= phase_nxt;
      gh_start_r  <= gh_start_nxt;
      rnd_r       <= rnd_nxt;
      widx_r      <= widx_nxt;
      out_valid_r <= out_valid_nxt;
      kexp_r      <= kexp_nxt;
      h_r         <= h_nxt;
      s_r         <= s_nxt;
      blk_r       <= blk_nxt;
      rcon_r      <= rcon_nxt;
      n_r         <= n_nxt;
      out_kind_r  <= out_kind_nxt;
      out_blk_r   <= out_blk_nxt;
      out_vb_r    <= out_vb_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {3'b000, out_vb_r, out_blk_r[63:0], out_blk_r[127:64]};

`ifndef ASSERT_OFF
  a_gh_done_in_gh: assert property (@(posedge clk) disable iff (!rst_n)
    gh_done |-> state_r == ST_GH)
    else $error("ghash finished outside the hash state");

  a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_REJ) |-> (out_tdata == '0))
    else $error("rejected transaction carries data");

  a_closed_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_DATA && phase_r == 2'd3) |=> state_r == ST_EMIT)
    else $error("payload accepted after a short final block");
`endif

endmodule

>>> test/aes128_gcm_encryptor_top_test.sv
// self-checking testbench for the aes-128-gcm encryptor top level
`timescale 1ns / 1ps

module aes128_gcm_encryptor_top_test
  import aesg_pkg::*;
;

  localparam int unsigned LEN_BITS    = 36;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_WAIT  = 120;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    kind_t       kind;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  nbytes;
  } gcm_result_t;

  typedef struct {
    cmd_t        cmd;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  nbytes;
    bit          typed;
    kind_t       ekind;
    logic [63:0] ehi;
    logic [63:0] elo;
    logic [4:0]  en;
  } stim_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;   // block_upper, block_lower, byte_count, zero pad
  logic [1:0]   in_tuser;   // command
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;  // result_upper, result_lower, valid_bytes, zero pad
  logic [1:0]   out_tuser;  // result_kind
  logic         cfg_wen;
  logic [1:0]   cfg_index;
  logic [63:0]  cfg_wdata;

  aes128_gcm_encryptor_top #(.LENGTH_BITS(LEN_BITS)) dut (.*);

  // predictor state
  logic [127:0] rk_mem [11];
  logic [127:0] h_sub;
  logic [127:0] hash_acc;
  logic [31:0]  ctr;
  logic [63:0]  aad_total;
  logic [63:0]  pay_total;
  logic [1:0]   phase;
  logic [63:0]  key_hi, key_lo, iv_hi;
  logic [31:0]  iv_lo;

  gcm_result_t  pending_results[$];
  int unsigned  mismatches;
  int unsigned  results_seen;
  int unsigned  items_sent;
  int unsigned  cycles;
  bit           calm;

  stim_row_t directed [21] = '{
    '{CMD_FIN,  '0, '0, 5'd16, 1, KIND_TAG, 64'h58e2fccefa7e3061, 64'h367f1d57a4e7455a, 5'd16},
    '{CMD_DATA, '0, '0, 5'd16, 1, KIND_CT,  64'h0388dace60b6a392, 64'hf328c2b971b2fe78, 5'd16},
    '{CMD_FIN,  '0, '0, 5'd0,  1, KIND_TAG, 64'hab6e47d42cec13bd, 64'hf53a67b21257bddf, 5'd16},
    '{CMD_BAD,  '1, '1, 5'd16, 1, KIND_REJ, '0, '0, 5'd0},
    '{CMD_AAD,  '1, '1, 5'd0,  1, KIND_REJ, '0, '0, 5'd0},
    '{CMD_DATA, '1, '1, 5'd17, 1, KIND_REJ, '0, '0, 5'd0},
    '{CMD_AAD,  '1, '1, 5'd31, 1, KIND_REJ, '0, '0, 5'd0},
    '{CMD_AAD,  '1, '1, 5'd16, 0, KIND_CT,  '0, '0, 5'd0},
    '{CMD_AAD,  '1, '1, 5'd1,  0, KIND_CT,  '0, '0, 5'd0},
    '{CMD_AAD,  '1, '1, 5'd16, 1, KIND_REJ, '0, '0, 5'd0},
    '{CMD_DATA, '1, '1, 5'd16, 0, KIND_CT,  '0, '0, 5'd0},
    '{CMD_DATA, '1, '1, 5'd15, 0, KIND_CT,  '0, '0, 5'd0},
    '{CMD_DATA, '1, '1, 5'd16, 1, KIND_REJ, '0, '0, 5'd0},
    '{CMD_AAD,  '0, '0, 5'd16, 1, KIND_REJ, '0, '0, 5'd0},
    '{CMD_FIN,  '1, '1, 5'd31, 0, KIND_CT,  '0, '0, 5'd0},
    '{CMD_DATA, '1, '1, 5'd1,  0, KIND_CT,  '0, '0, 5'd0},
    '{CMD_DATA, '0, '1, 5'd16, 1, KIND_REJ, '0, '0, 5'd0},
    '{CMD_FIN,  '0, '0, 5'd3,  0, KIND_CT,  '0, '0, 5'd0},
    '{CMD_AAD,  '0, '0, 5'd16, 0, KIND_CT,  '0, '0, 5'd0},
    '{CMD_DATA, 64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a, 5'd8, 0, KIND_CT, '0, '0, 5'd0},
    '{CMD_FIN,  '0, '0, 5'd16, 0, KIND_CT,  '0, '0, 5'd0}
  };

  function automatic logic [7:0] dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [127:0] encrypt_block(input logic [127:0] pt);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a, b, d, e;
    for (int i = 0; i < 16; i++) s[i] = pt[127-8*i -: 8] ^ rk_mem[0][127-8*i -: 8];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++)
          t[c*4+w] = SBOX[s[((c+w)&3)*4+w]];
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a = t[4*c]; b = t[4*c+1]; d = t[4*c+2]; e = t[4*c+3];
          t[4*c]   = dbl(a) ^ dbl(b) ^ b ^ d ^ e;
          t[4*c+1] = a ^ dbl(b) ^ dbl(d) ^ d ^ e;
          t[4*c+2] = a ^ b ^ dbl(d) ^ dbl(e) ^ e;
          t[4*c+3] = dbl(a) ^ a ^ b ^ d ^ dbl(e);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk_mem[r][127-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) encrypt_block[127-8*i -: 8] = s[i];
  endfunction

  task automatic expand_key();
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    w[0] = key_hi[63:32]; w[1] = key_hi[31:0]; w[2] = key_lo[63:32]; w[3] = key_lo[31:0];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {SBOX[t[23:16]] ^ rc, SBOX[t[15:8]], SBOX[t[7:0]], SBOX[t[31:24]]};
        rc = dbl(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) rk_mem[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    h_sub = encrypt_block('0);
  endtask

  function automatic logic [127:0] gf_mult(input logic [127:0] x, input logic [127:0] y);
    logic [127:0] z, v;
    logic         lsb;
    z = '0;
    v = y;
    for (int i = 0; i < 128; i++) begin
      if (x[127-i]) z ^= v;
      lsb = v[0];
      v = v >> 1;
      if (lsb) v[127:120] ^= 8'hE1;
    end
    return z;
  endfunction

  task automatic clear_message();
    hash_acc = '0;
    ctr = 32'd1;
    aad_total = '0;
    pay_total = '0;
    phase = 2'd0;
  endtask

  // advances the model by one accepted transaction; returns 1 when a result follows
  task automatic gcm_advance(input cmd_t cmd, input logic [127:0] blk_in, input logic [4:0] n,
                             output bit has, output gcm_result_t res);
    logic [63:0]  maxlen;
    logic [127:0] blk, ks;
    maxlen = (64'd1 << LEN_BITS) - 1;
    has = 1;
    res = '{KIND_REJ, '0, '0, 5'd0};
    if (cmd == CMD_FIN) begin
      hash_acc = gf_mult(hash_acc ^ {aad_total << 3, pay_total << 3}, h_sub);
      ks = encrypt_block({iv_hi, iv_lo, 32'd1}) ^ hash_acc;
      res = '{KIND_TAG, ks[127:64], ks[63:0], 5'd16};
      clear_message();
      return;
    end
    if (cmd == CMD_BAD || n == 0 || n > 16) return;
    blk = blk_in & ~({128{1'b1}} >> (n * 8));
    if (cmd == CMD_AAD) begin
      if (phase != 0 || aad_total > maxlen - n) return;
      hash_acc = gf_mult(hash_acc ^ blk, h_sub);
      aad_total += n;
      if (n < 16) phase = 2'd1;
      has = 0;
      return;
    end
    if (phase == 3 || pay_total > maxlen - n) return;
    ctr = ctr + 1;
    ks = encrypt_block({iv_hi, iv_lo, ctr});
    blk = blk ^ (ks & ~({128{1'b1}} >> (n * 8)));
    hash_acc = gf_mult(hash_acc ^ blk, h_sub);
    pay_total += n;
    phase = (n < 16) ? 2'd3 : 2'd2;
    res = '{KIND_CT, blk[127:64], blk[63:0], n};
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls and comparison
  int unsigned stall_left;
  always @(posedge clk) begin
    gcm_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (pending_results.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_REPORTS)
            $display("unexpected result: kind %0d data %h", out_tuser, out_tdata);
        end else begin
          want = pending_results.pop_front();
          if (out_tuser !== want.kind || out_tdata[63:0] !== want.hi ||
              out_tdata[127:64] !== want.lo || out_tdata[132:128] !== want.nbytes) begin
            mismatches <= mismatches + 1;
            if (mismatches < MAX_REPORTS)
              $display("result mismatch: expected kind %0d %h %h n %0d, got kind %0d %h %h n %0d",
                       want.kind, want.hi, want.lo, want.nbytes, out_tuser,
                       out_tdata[63:0], out_tdata[127:64], out_tdata[132:128]);
          end
        end
        stall_left <= calm ? 0 : $urandom_range(0, 9);
        out_tready <= calm || ($urandom_range(0, 9) == 0);
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input cmd_t cmd, input logic [63:0] hi, input logic [63:0] lo,
                           input logic [4:0] n, input bit typed, input gcm_result_t typed_res);
    int unsigned gap;
    bit          has;
    gcm_result_t res;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {3'b000, n, lo, hi};
    do @(posedge clk); while (!in_tready);
    gcm_advance(cmd, {hi, lo}, n, has, res);
    if (typed) begin
      has = 1;
      res = typed_res;
    end
    if (has) pending_results.push_back(res);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_KEY_HI:   begin key_hi = val; expand_key(); end
      REG_KEY_LO:   begin key_lo = val; expand_key(); end
      REG_NONCE_HI: iv_hi = val;
      REG_NONCE_LO: iv_lo = val[31:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input logic [63:0] k1, input logic [63:0] k0,
                              input logic [63:0] v1, input logic [31:0] v0);
    write_reg(REG_KEY_HI, k1);
    write_reg(REG_KEY_LO, k0);
    write_reg(REG_NONCE_HI, v1);
    write_reg(REG_NONCE_LO, {32'd0, v0});
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [4:0] rand_len();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(1, 15)) : 5'd16;
  endfunction

  // one message: associated data, payload, tag; now and then a stray transaction
  task automatic send_message();
    gcm_result_t none;
    int unsigned naad, npay;
    logic [4:0]  n;
    none = '{KIND_REJ, '0, '0, 5'd0};
    naad = $urandom_range(0, 3);
    npay = $urandom_range(0, 6);
    for (int i = 0; i < naad; i++) begin
      n = rand_len();
      send_item(CMD_AAD, rand64(), rand64(), n, 0, none);
    end
    for (int i = 0; i < npay; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(cmd_t'($urandom_range(0, 3)), rand64(), rand64(),
                  5'($urandom_range(0, 31)), 0, none);
      n = rand_len();
      send_item(CMD_DATA, rand64(), rand64(), n, 0, none);
    end
    send_item(CMD_FIN, rand64(), rand64(), 5'($urandom_range(0, 31)), 0, none);
  endtask

  initial begin
    gcm_result_t typed_res;
    logic [63:0] settings [6][4];
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_AAD;
    cfg_wen = 1'b0;
    cfg_index = REG_KEY_HI;
    cfg_wdata = '0;
    out_tready = 1'b0;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    cycles = 0;
    calm = 0;
    key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
    expand_key();
    clear_message();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      typed_res = '{directed[i].ekind, directed[i].ehi, directed[i].elo, directed[i].en};
      send_item(directed[i].cmd, directed[i].hi, directed[i].lo, directed[i].nbytes,
                directed[i].typed, typed_res);
    end
    wait_idle();

    settings[0] = '{'1, '1, '1, 64'hFFFFFFFF};
    settings[1] = '{'0, '0, '1, 64'hFFFFFFFF};
    settings[2] = '{64'hfeffe9928665731c, 64'h6d6a8f9467308308,
                    64'hcafebabefacedbad, 64'hdecaf888};
    settings[3] = '{rand64(), rand64(), rand64(), 64'($urandom)};
    settings[4] = '{rand64(), rand64(), '0, 64'd0};
    settings[5] = '{rand64(), rand64(), rand64(), 64'($urandom)};
    foreach (settings[p]) begin
      load_setting(settings[p][0], settings[p][1], settings[p][2], settings[p][3][31:0]);
      calm = (p == 2);
      while (items_sent < 21 + (p + 1) * 130) send_message();
      wait_idle();
    end

    $display("%0d transactions sent, %0d results checked over 7 key and nonce settings",
             items_sent, results_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching results", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
